### design/dmkd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the duplex matrix key debouncer.
// No dependencies; used by every module of the block except dmkd_ram.
package dmkd_pkg;

  // Default sizing, handed to the top-level parameters
  localparam int unsigned MAX_ROWS_DEF      = 8;
  localparam int unsigned MAX_PHYS_COLS_DEF = 8;
  localparam int unsigned COUNTER_BITS_DEF  = 16;

  // Register file
  localparam int unsigned CFG_MS_W   = 16;  // debounce / poll time registers
  localparam int unsigned CFG_CNT_W  = 4;   // row / column count registers
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_PRESS_MS   = 3'd0,
    REG_RELEASE_MS = 3'd1,
    REG_POLL_MS    = 3'd2,
    REG_ROWS       = 3'd3,
    REG_PHYS_COLS  = 3'd4
  } reg_idx_e;

  localparam logic [CFG_MS_W-1:0]  PRESS_MS_RST   = 16'd5;
  localparam logic [CFG_MS_W-1:0]  RELEASE_MS_RST = 16'd5;
  localparam logic [CFG_MS_W-1:0]  POLL_MS_RST    = 16'd1;
  localparam logic [CFG_CNT_W-1:0] ROWS_RST       = 4'd8;
  localparam logic [CFG_CNT_W-1:0] PHYS_COLS_RST  = 4'd8;

  // Thresholds that go with the reset register values
  localparam logic [CFG_MS_W-1:0] PRESS_LIM_RST   = PRESS_MS_RST / POLL_MS_RST;
  localparam logic [CFG_MS_W-1:0] RELEASE_LIM_RST = RELEASE_MS_RST / POLL_MS_RST;

  // Queue between classifier and cell update, power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  // Field widths of the stream words
  localparam int unsigned ROW_W  = 3;
  localparam int unsigned COL_W  = 3;
  localparam int unsigned LCOL_W = 4;

  typedef struct packed {
    logic              raw;
    logic [LCOL_W-1:0] ev_col;
    logic [ROW_W-1:0]  row;
  } cell_req_t;

  typedef struct packed {
    logic init_done;
    logic cfg_busy;
  } fe_ctl_t;

  typedef struct packed {
    logic [CFG_MS_W-1:0] prs;
    logic [CFG_MS_W-1:0] rel;
  } limits_t;

endpackage

### design/dmkd_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dmkd_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/dmkd_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the debounce thresholds.
// Depends on dmkd_pkg.
module dmkd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dmkd_pkg::CFG_MS_W-1:0] dividend_i,
  input  logic [dmkd_pkg::CFG_MS_W-1:0] divisor_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [dmkd_pkg::CFG_MS_W-1:0] quotient_o
);

  localparam int unsigned W      = dmkd_pkg::CFG_MS_W;
  localparam int unsigned STEP_W = $clog2(W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [W-1:0]      rem_q, rem_d;
  logic [W-1:0]      quo_q, quo_d;
  logic [W-1:0]      dvs_q, dvs_d;
  logic [W:0]        trial;
  logic [W:0]        diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[W-1]};
    diff   = trial - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
      end else begin
        rem_d = trial[W-1:0];
      end
      quo_d  = {quo_q[W-2:0], ~diff[W]};
      step_d = step_q - STEP_W'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### design/dmkd_front.sv
`timescale 1ns / 1ps
// Front end: takes raw readings, drops out-of-range ones, maps the rest to a
// cell address and queues them for the cell update. Depends on dmkd_pkg.
module dmkd_front #(
  parameter int unsigned MAX_ROWS      = dmkd_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_PHYS_COLS = dmkd_pkg::MAX_PHYS_COLS_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            s_axis_tvalid,
  output logic                                            s_axis_tready,
  input  logic [7:0]                                      s_axis_tdata,
  input  logic [0:0]                                      s_axis_tuser,
  input  logic [dmkd_pkg::CFG_CNT_W-1:0]                  rows_in_use_i,
  input  logic [dmkd_pkg::CFG_CNT_W-1:0]                  phys_cols_in_use_i,
  input  dmkd_pkg::fe_ctl_t                               ctl_i,
  output logic                                            q_valid_o,
  output dmkd_pkg::cell_req_t                             q_req_o,
  output logic [$clog2(MAX_ROWS*2*MAX_PHYS_COLS)-1:0]     q_addr_o,
  input  logic                                            q_pop_i
);

  localparam int unsigned LOGICAL_COLS = 2 * MAX_PHYS_COLS;
  localparam int unsigned CELL_COUNT   = MAX_ROWS * LOGICAL_COLS;
  localparam int unsigned ADDR_W       = $clog2(CELL_COUNT);
  localparam int unsigned NC_MAX       = (MAX_PHYS_COLS > 15) ? MAX_PHYS_COLS : 15;
  localparam int unsigned NC_W         = $clog2(NC_MAX + 1);
  localparam int unsigned SUM_W        = NC_W + 1;
  localparam int unsigned DEPTH        = dmkd_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned QCNT_W       = $clog2(DEPTH + 1);

  logic [dmkd_pkg::ROW_W-1:0] row;
  logic [dmkd_pkg::COL_W-1:0] col;
  logic                       raw;
  logic                       mode;
  logic [NC_W-1:0]            ncols;
  logic [SUM_W-1:0]           lsum;
  logic                       in_range;
  logic                       accept;
  logic                       push;
  logic [ADDR_W-1:0]          addr;
  dmkd_pkg::cell_req_t        req;

  dmkd_pkg::cell_req_t        req_mem_q  [DEPTH];
  logic [ADDR_W-1:0]          addr_mem_q [DEPTH];
  logic [PTR_W-1:0]           wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]           rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]          cnt_q, cnt_d;

  // tdata: [2:0] row_index, [5:3] col_index, [6] raw_pressed
  assign row  = s_axis_tdata[2:0];
  assign col  = s_axis_tdata[5:3];
  assign raw  = s_axis_tdata[6];
  assign mode = s_axis_tuser[0];

  always_comb begin
    if (int'(phys_cols_in_use_i) > int'(MAX_PHYS_COLS)) begin
      ncols = NC_W'(MAX_PHYS_COLS);
    end else begin
      ncols = NC_W'(phys_cols_in_use_i);
    end
    // reverse scan lands just above the forward columns in use
    lsum     = SUM_W'(col) + (mode ? SUM_W'(ncols) : '0);
    in_range = (int'(row) < int'(rows_in_use_i)) && (int'(row) < int'(MAX_ROWS)) &&
               (int'(col) < int'(ncols));
    addr     = ADDR_W'(int'(row) * int'(LOGICAL_COLS) + int'(lsum));
    req.raw    = raw;
    req.ev_col = lsum[dmkd_pkg::LCOL_W-1:0];
    req.row    = row;
  end

  assign s_axis_tready = ctl_i.init_done && !ctl_i.cfg_busy && (cnt_q != QCNT_W'(DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push          = accept && in_range;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (q_pop_i) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      req_mem_q[wr_ptr_q]  <= req;
      addr_mem_q[wr_ptr_q] <= addr;
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_req_o   = req_mem_q[rd_ptr_q];
  assign q_addr_o  = addr_mem_q[rd_ptr_q];

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QCNT_W'(DEPTH))
    else $error("front queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> cnt_q != '0)
    else $error("pop from empty front queue");

endmodule

### design/dmkd_back.sv
`timescale 1ns / 1ps
// Back end: read-modify-write of one cell per queued word, event output register,
// and the clearing sweep of the cell store after reset. Depends on dmkd_pkg, dmkd_ram.
module dmkd_back #(
  parameter int unsigned MAX_ROWS      = dmkd_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_PHYS_COLS = dmkd_pkg::MAX_PHYS_COLS_DEF,
  parameter int unsigned COUNTER_BITS  = dmkd_pkg::COUNTER_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        q_valid_i,
  input  dmkd_pkg::cell_req_t                         q_req_i,
  input  logic [$clog2(MAX_ROWS*2*MAX_PHYS_COLS)-1:0] q_addr_i,
  output logic                                        q_pop_o,
  input  dmkd_pkg::limits_t                           limits_i,
  output logic                                        init_done_o,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  output logic [7:0]                                  m_axis_tdata
);

  localparam int unsigned CELL_COUNT = MAX_ROWS * 2 * MAX_PHYS_COLS;
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);
  localparam int unsigned CELL_W     = COUNTER_BITS + 2;
  localparam int unsigned MS_W       = dmkd_pkg::CFG_MS_W;

  // cell layout: [CB+1] stable, [CB] candidate, [CB-1:0] counter
  logic                    init_done_q, init_done_d;
  logic [ADDR_W-1:0]       clr_addr_q, clr_addr_d;
  logic                    m_valid_q, m_valid_d;
  dmkd_pkg::cell_req_t     m_req_q;
  logic [ADDR_W-1:0]       m_addr_q;
  logic                    out_valid_q, out_valid_d;
  logic [7:0]              out_data_q;

  logic                    rd_fire;
  logic                    complete;
  logic [CELL_W-1:0]       rdata;
  logic [COUNTER_BITS-1:0] cnt_rd, cnt_base, cnt_n;
  logic                    cand_rd, stab_rd, stab_n, cand_n;
  logic                    hit;
  logic [MS_W-1:0]         limit;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [CELL_W-1:0]       ram_wdata;

  assign rd_fire  = init_done_q && q_valid_i && !m_valid_q;
  assign complete = m_valid_q && (!out_valid_q || m_axis_tready);
  assign q_pop_o  = rd_fire;

  always_comb begin
    cnt_rd  = rdata[COUNTER_BITS-1:0];
    cand_rd = rdata[COUNTER_BITS];
    stab_rd = rdata[COUNTER_BITS+1];
    cand_n  = m_req_q.raw;
    limit   = m_req_q.raw ? limits_i.prs : limits_i.rel;
    // a new raw value restarts the count
    cnt_base = (m_req_q.raw != cand_rd) ? '0 : cnt_rd;
    cnt_n    = cnt_base;
    hit      = 1'b0;
    if (cand_n != stab_rd) begin
      cnt_n = (cnt_base == '1) ? cnt_base : cnt_base + COUNTER_BITS'(1);
      hit   = MS_W'(cnt_n) > limit;
    end
    stab_n = hit ? cand_n : stab_rd;
  end

  always_comb begin
    if (!init_done_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = complete;
      ram_waddr = m_addr_q;
      ram_wdata = {stab_n, cand_n, cnt_n};
    end
  end

  dmkd_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_fire),
    .raddr_i (q_addr_i),
    .rdata_o (rdata)
  );

  always_comb begin
    init_done_d = init_done_q;
    clr_addr_d  = clr_addr_q;
    if (!init_done_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(CELL_COUNT - 1)) begin
        init_done_d = 1'b1;
      end
    end
    m_valid_d = m_valid_q;
    if (rd_fire) begin
      m_valid_d = 1'b1;
    end else if (complete) begin
      m_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (complete && hit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_done_q <= 1'b0;
      clr_addr_q  <= '0;
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      init_done_q <= init_done_d;
      clr_addr_q  <= clr_addr_d;
      m_valid_q   <= m_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      m_req_q  <= q_req_i;
      m_addr_q <= q_addr_i;
    end
    if (complete && hit) begin
      out_data_q <= {stab_n, m_req_q.ev_col, m_req_q.row};
    end
  end

  assign init_done_o   = init_done_q;
  assign m_axis_tvalid = out_valid_q;
  // tdata: [2:0] event_row, [6:3] event_col, [7] event_pressed
  assign m_axis_tdata  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !init_done_q |-> !m_valid_q)
    else $error("cell update during clearing sweep");

  assert property (@(posedge clk_i) disable iff (!rst_ni) init_done_q |=> init_done_q)
    else $error("clearing sweep restarted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !complete) |=> (m_valid_q && $stable(m_addr_q)))
    else $error("stalled cell update lost its address");

endmodule

### design/duplex_matrix_key_debouncer_core.sv
`timescale 1ns / 1ps
// Top level of the duplex key matrix debouncer: register file, threshold dividers,
// front end and cell-update back end. Depends on dmkd_pkg, dmkd_div, dmkd_front, dmkd_back.
//
// Takes raw key-matrix readings as 8-bit words and emits one event word whenever a cell's
// debounced state flips. After reset the cell store (MAX_ROWS*2*MAX_PHYS_COLS entries, 128
// by default) is cleared one entry per cycle, and the input is held off until the sweep is done.
// A cell update is a read-modify-write of the simple dual-port cell RAM; the back end takes
// no new reading until the last update is written. A reading outside the rows and columns
// in use is taken and dropped. A two-word queue and the output register let either side
// stall alone. Writing the press, release or poll register recomputes both thresholds with
// bit-serial dividers; the input is held off until they are done.
module duplex_matrix_key_debouncer_core #(
  parameter int unsigned MAX_ROWS      = dmkd_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_PHYS_COLS = dmkd_pkg::MAX_PHYS_COLS_DEF,
  parameter int unsigned COUNTER_BITS  = dmkd_pkg::COUNTER_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: [2:0] row_index, [5:3] col_index, [6] raw_pressed, [7] zero
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,
  // tuser: [0] mode
  input  logic [0:0]                        s_axis_tuser,
  // tdata: [2:0] event_row, [6:3] event_col, [7] event_pressed
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dmkd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [dmkd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [dmkd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int unsigned ADDR_W = $clog2(MAX_ROWS * 2 * MAX_PHYS_COLS);
  localparam int unsigned MS_W   = dmkd_pkg::CFG_MS_W;
  localparam int unsigned CNT_W  = dmkd_pkg::CFG_CNT_W;
  localparam int unsigned DATA_W = dmkd_pkg::APB_DATA_W;

  logic [MS_W-1:0]     press_ms_q, release_ms_q, poll_ms_q;
  logic [CNT_W-1:0]    rows_q, cols_q;
  logic [MS_W-1:0]     prs_lim_q, rel_lim_q;
  logic                recalc_q, recalc_d;
  logic                cfg_wr;
  logic [2:0]          reg_idx;
  logic [MS_W-1:0]     divisor;
  logic                prs_busy, rel_busy, prs_done, rel_done;
  logic [MS_W-1:0]     prs_quo, rel_quo;
  logic                cfg_busy;
  dmkd_pkg::fe_ctl_t   fe_ctl;
  dmkd_pkg::limits_t   limits;
  logic                init_done;
  logic                q_valid, q_pop;
  dmkd_pkg::cell_req_t q_req;
  logic [ADDR_W-1:0]   q_addr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    recalc_d = 1'b0;
    if (cfg_wr) begin
      recalc_d = (reg_idx == dmkd_pkg::REG_PRESS_MS) ||
                 (reg_idx == dmkd_pkg::REG_RELEASE_MS) ||
                 (reg_idx == dmkd_pkg::REG_POLL_MS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_ms_q   <= dmkd_pkg::PRESS_MS_RST;
      release_ms_q <= dmkd_pkg::RELEASE_MS_RST;
      poll_ms_q    <= dmkd_pkg::POLL_MS_RST;
      rows_q       <= dmkd_pkg::ROWS_RST;
      cols_q       <= dmkd_pkg::PHYS_COLS_RST;
      recalc_q     <= 1'b0;
      prs_lim_q    <= dmkd_pkg::PRESS_LIM_RST;
      rel_lim_q    <= dmkd_pkg::RELEASE_LIM_RST;
    end else begin
      recalc_q <= recalc_d;
      if (cfg_wr) begin
        case (reg_idx)
          dmkd_pkg::REG_PRESS_MS:   press_ms_q   <= pwdata[MS_W-1:0];
          dmkd_pkg::REG_RELEASE_MS: release_ms_q <= pwdata[MS_W-1:0];
          dmkd_pkg::REG_POLL_MS:    poll_ms_q    <= pwdata[MS_W-1:0];
          dmkd_pkg::REG_ROWS:       rows_q       <= pwdata[CNT_W-1:0];
          dmkd_pkg::REG_PHYS_COLS:  cols_q       <= pwdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (prs_done) begin
        prs_lim_q <= prs_quo;
      end
      if (rel_done) begin
        rel_lim_q <= rel_quo;
      end
    end
  end

  always_comb begin
    case (reg_idx)
      dmkd_pkg::REG_PRESS_MS:   prdata = DATA_W'(press_ms_q);
      dmkd_pkg::REG_RELEASE_MS: prdata = DATA_W'(release_ms_q);
      dmkd_pkg::REG_POLL_MS:    prdata = DATA_W'(poll_ms_q);
      dmkd_pkg::REG_ROWS:       prdata = DATA_W'(rows_q);
      dmkd_pkg::REG_PHYS_COLS:  prdata = DATA_W'(cols_q);
      default:                  prdata = '0;
    endcase
  end

  // zero poll period counts as one
  assign divisor = (poll_ms_q == '0) ? MS_W'(1) : poll_ms_q;

  dmkd_div u_prs_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (recalc_q),
    .dividend_i (press_ms_q),
    .divisor_i  (divisor),
    .busy_o     (prs_busy),
    .done_o     (prs_done),
    .quotient_o (prs_quo)
  );

  dmkd_div u_rel_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (recalc_q),
    .dividend_i (release_ms_q),
    .divisor_i  (divisor),
    .busy_o     (rel_busy),
    .done_o     (rel_done),
    .quotient_o (rel_quo)
  );

  assign cfg_busy         = recalc_q || prs_busy || rel_busy;
  assign fe_ctl.init_done = init_done;
  assign fe_ctl.cfg_busy  = cfg_busy;
  assign limits.prs       = prs_lim_q;
  assign limits.rel       = rel_lim_q;

  dmkd_front #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_PHYS_COLS (MAX_PHYS_COLS)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .s_axis_tvalid      (s_axis_tvalid),
    .s_axis_tready      (s_axis_tready),
    .s_axis_tdata       (s_axis_tdata),
    .s_axis_tuser       (s_axis_tuser),
    .rows_in_use_i      (rows_q),
    .phys_cols_in_use_i (cols_q),
    .ctl_i              (fe_ctl),
    .q_valid_o          (q_valid),
    .q_req_o            (q_req),
    .q_addr_o           (q_addr),
    .q_pop_i            (q_pop)
  );

  dmkd_back #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_PHYS_COLS (MAX_PHYS_COLS),
    .COUNTER_BITS  (COUNTER_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_req_i       (q_req),
    .q_addr_i      (q_addr),
    .q_pop_o       (q_pop),
    .limits_i      (limits),
    .init_done_o   (init_done),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_busy |-> !s_axis_tready)
    else $error("word taken while thresholds are recomputed");

  assert property (@(posedge clk_i) disable iff (!rst_ni) prs_done |-> rel_done)
    else $error("threshold dividers out of step");

endmodule

### tb/duplex_matrix_key_debouncer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for duplex_matrix_key_debouncer_core: directed and random matrix
// readings on the input stream, event words checked against a cycle-free debounce predictor.
// Depends on dmkd_pkg and the core RTL only.
module duplex_matrix_key_debouncer_core_tb;
  import dmkd_pkg::*;

  localparam int unsigned NUM_ROWS    = MAX_ROWS_DEF;
  localparam int unsigned NUM_PCOLS   = MAX_PHYS_COLS_DEF;
  localparam int unsigned NUM_LCOLS   = 2 * NUM_PCOLS;
  localparam int unsigned NUM_CELLS   = NUM_ROWS * NUM_LCOLS;
  localparam int unsigned CNT_W       = COUNTER_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE_CYC  = 24;   // > divider hold-off plus pipeline depth
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_WORDS = 40;
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = 5'd20;

  // same layout as the event tdata word
  typedef struct packed {
    logic              pressed;
    logic [LCOL_W-1:0] col;
    logic [ROW_W-1:0]  row;
  } key_event_t;

  typedef struct packed {
    logic                  is_wr;
    logic [APB_ADDR_W-1:0] addr;
    logic [APB_DATA_W-1:0] wdata;
    logic                  mode;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic                  raw;
    logic                  typed;
    key_event_t            want;
  } plan_step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // predictor state
  logic [CFG_MS_W-1:0]  cfg_press   = PRESS_MS_RST;
  logic [CFG_MS_W-1:0]  cfg_release = RELEASE_MS_RST;
  logic [CFG_MS_W-1:0]  cfg_poll    = POLL_MS_RST;
  logic [CFG_CNT_W-1:0] cfg_rows    = ROWS_RST;
  logic [CFG_CNT_W-1:0] cfg_cols    = PHYS_COLS_RST;
  logic                 cell_stable [NUM_CELLS];
  logic                 cell_cand   [NUM_CELLS];
  logic [CNT_W-1:0]     cell_cnt    [NUM_CELLS];

  key_event_t pending_events[$];
  plan_step_t plan[$];
  int         error_count = 0;
  int         cycle_count = 0;
  int         stall_left = 0;
  bit         idle_en = 1'b1;

  duplex_matrix_key_debouncer_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned debounce_limit(input logic pressed);
    int unsigned ms;
    int unsigned per;
    ms  = pressed ? cfg_press : cfg_release;
    per = (cfg_poll == 0) ? 1 : cfg_poll;
    return ms / per;
  endfunction

  // One reading through the debounce state; returns 1 when the stable bit flips.
  function automatic logic debounce_step(input logic mode, input logic [ROW_W-1:0] row,
                                         input logic [COL_W-1:0] col, input logic raw,
                                         output key_event_t ev, output logic in_range);
    int unsigned nrows;
    int unsigned ncols;
    int unsigned lcol;
    int unsigned idx;
    ev       = '0;
    nrows    = (cfg_rows > NUM_ROWS) ? NUM_ROWS : cfg_rows;
    ncols    = (cfg_cols > NUM_PCOLS) ? NUM_PCOLS : cfg_cols;
    in_range = (row < nrows) && (col < ncols);
    if (!in_range) return 1'b0;
    lcol = mode ? col + ncols : col;
    idx  = row * NUM_LCOLS + lcol;
    if (raw != cell_cand[idx]) begin
      cell_cand[idx] = raw;
      cell_cnt[idx]  = '0;
    end
    if (cell_cand[idx] == cell_stable[idx]) return 1'b0;
    if (cell_cnt[idx] != '1) cell_cnt[idx] = cell_cnt[idx] + 1'b1;
    if (cell_cnt[idx] > debounce_limit(raw)) begin
      cell_stable[idx] = cell_cand[idx];
      ev.row     = row;
      ev.col     = lcol[LCOL_W-1:0];
      ev.pressed = cell_stable[idx];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [APB_ADDR_W-1:0] reg_addr(input reg_idx_e r);
    return {r, 2'b00};
  endfunction

  function automatic void plan_write(input logic [APB_ADDR_W-1:0] addr,
                                     input logic [APB_DATA_W-1:0] data);
    plan_step_t s;
    s       = '0;
    s.is_wr = 1'b1;
    s.addr  = addr;
    s.wdata = data;
    plan.push_back(s);
  endfunction

  function automatic void plan_read(input logic mode, input logic [ROW_W-1:0] row,
                                    input logic [COL_W-1:0] col, input logic raw,
                                    input logic typed = 1'b0, input key_event_t want = '0);
    plan_step_t s;
    s       = '0;
    s.mode  = mode;
    s.row   = row;
    s.col   = col;
    s.raw   = raw;
    s.typed = typed;
    s.want  = want;
    plan.push_back(s);
  endfunction

  task automatic send_reading(input logic mode, input logic [ROW_W-1:0] row,
                              input logic [COL_W-1:0] col, input logic raw,
                              input logic typed, input key_event_t typed_ev,
                              output logic in_range);
    key_event_t ev;
    logic       fired;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, raw, col, row};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    fired = debounce_step(mode, row, col, raw, ev, in_range);
    if (typed) pending_events.push_back(typed_ev);
    else if (fired) pending_events.push_back(ev);
  endtask

  // Hold the input, let every expected event out, then let the block settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr[APB_ADDR_W-1:2])
      REG_PRESS_MS:   cfg_press   = data[CFG_MS_W-1:0];
      REG_RELEASE_MS: cfg_release = data[CFG_MS_W-1:0];
      REG_POLL_MS:    cfg_poll    = data[CFG_MS_W-1:0];
      REG_ROWS:       cfg_rows    = data[CFG_CNT_W-1:0];
      REG_PHYS_COLS:  cfg_cols    = data[CFG_CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic check_regs();
    logic [APB_DATA_W-1:0] want;
    for (int i = 0; i <= REG_PHYS_COLS; i++) begin
      case (i)
        REG_PRESS_MS:   want = cfg_press;
        REG_RELEASE_MS: want = cfg_release;
        REG_POLL_MS:    want = cfg_poll;
        REG_ROWS:       want = cfg_rows;
        default:        want = cfg_cols;
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= reg_addr(reg_idx_e'(i));
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (prdata !== want) begin
        error_count++;
        $display("%0t: register %0d readback: expected %0h, actual %0h",
                 $time, i, want, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Event sink: random stall bursts, every accepted word checked in order.
  always @(posedge clk_i) begin
    key_event_t got;
    key_event_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_events.size() == 0) begin
        error_count++;
        $display("%0t: event with none expected: expected none, actual %h", $time, got);
      end else begin
        want = pending_events.pop_front();
        if (got.row !== want.row) begin
          error_count++;
          $display("%0t: event_row: expected %0d, actual %0d", $time, want.row, got.row);
        end
        if (got.col !== want.col) begin
          error_count++;
          $display("%0t: event_col: expected %0d, actual %0d", $time, want.col, got.col);
        end
        if (got.pressed !== want.pressed) begin
          error_count++;
          $display("%0t: event_pressed: expected %0d, actual %0d",
                   $time, want.pressed, got.pressed);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 15);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    logic [CFG_MS_W-1:0]  v_press;
    logic [CFG_MS_W-1:0]  v_release;
    logic [CFG_MS_W-1:0]  v_poll;
    logic [CFG_CNT_W-1:0] v_rows;
    logic [CFG_CNT_W-1:0] v_cols;
    logic                 taken;
    logic                 mode;
    logic                 target;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
    int unsigned          nrows;
    int unsigned          ncols;
    int unsigned          lim;
    int unsigned          reps;
    int                   counted;
    int                   tries;

    for (int i = 0; i < NUM_CELLS; i++) begin
      cell_stable[i] = 1'b0;
      cell_cand[i]   = 1'b0;
      cell_cnt[i]    = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_regs();

    // directed part
    plan_read(1'b0, 3'd0, 3'd0, 1'b1);
    plan_read(1'b0, 3'd0, 3'd0, 1'b0);                 // bounce back before settling
    plan_write(reg_addr(REG_PRESS_MS), 32'd0);
    plan_write(reg_addr(REG_RELEASE_MS), 32'd0);
    plan_read(1'b0, 3'd0, 3'd0, 1'b1, 1'b1, {1'b1, 4'd0, 3'd0});
    plan_read(1'b1, 3'd7, 3'd7, 1'b1, 1'b1, {1'b1, 4'd15, 3'd7});
    plan_read(1'b1, 3'd7, 3'd7, 1'b1);
    plan_read(1'b1, 3'd7, 3'd7, 1'b0, 1'b1, {1'b0, 4'd15, 3'd7});
    plan_read(1'b0, 3'd7, 3'd7, 1'b1, 1'b1, {1'b1, 4'd7, 3'd7});
    plan_write(reg_addr(REG_ROWS), 32'hFFFF_FFF3);      // upper bits masked off
    plan_write(reg_addr(REG_PHYS_COLS), 32'd5);
    plan_read(1'b0, 3'd3, 3'd0, 1'b1);                  // row out of range
    plan_read(1'b0, 3'd0, 3'd5, 1'b1);                  // column out of range
    plan_read(1'b1, 3'd2, 3'd4, 1'b1, 1'b1, {1'b1, 4'd9, 3'd2});
    plan_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    plan_read(1'b1, 3'd2, 3'd4, 1'b0, 1'b1, {1'b0, 4'd9, 3'd2});
    plan_write(reg_addr(REG_ROWS), 32'd0);              // zero rows: all ignored
    plan_read(1'b0, 3'd0, 3'd1, 1'b1);
    plan_read(1'b1, 3'd0, 3'd1, 1'b1);
    plan_write(reg_addr(REG_ROWS), 32'd15);             // oversized counts saturate
    plan_write(reg_addr(REG_PHYS_COLS), 32'd15);
    plan_read(1'b1, 3'd7, 3'd7, 1'b1, 1'b1, {1'b1, 4'd15, 3'd7});
    plan_read(1'b0, 3'd1, 3'd2, 1'b0);
    plan_write(reg_addr(REG_PRESS_MS), 32'h0000_FFFF);
    plan_write(reg_addr(REG_RELEASE_MS), 32'h0000_FFFF);
    plan_write(reg_addr(REG_POLL_MS), 32'h0000_FFFF);
    plan_read(1'b0, 3'd5, 3'd3, 1'b1);
    plan_read(1'b0, 3'd5, 3'd3, 1'b1);
    plan_read(1'b0, 3'd5, 3'd3, 1'b0);
    plan_read(1'b0, 3'd5, 3'd3, 1'b0);
    plan_write(reg_addr(REG_POLL_MS), 32'd0);           // threshold at counter max
    plan_read(1'b0, 3'd6, 3'd6, 1'b1);
    plan_read(1'b0, 3'd6, 3'd6, 1'b1);
    plan_read(1'b0, 3'd6, 3'd6, 1'b1);

    foreach (plan[i]) begin
      if (plan[i].is_wr) begin
        wait_drained();
        apb_write(plan[i].addr, plan[i].wdata);
      end else begin
        send_reading(plan[i].mode, plan[i].row, plan[i].col, plan[i].raw,
                     plan[i].typed, plan[i].want, taken);
      end
    end
    wait_drained();
    check_regs();

    // random phases: bounce noise followed by a steady run, long enough to settle for thresholds below 12
    for (int ph = 0; ph < PHASES; ph++) begin
      idle_en = (ph < PHASES - 2);
      case (ph % 5)
        0: begin
          v_press   = $urandom_range(0, 10);
          v_release = $urandom_range(0, 10);
          v_poll    = $urandom_range(0, 3);
          v_rows    = $urandom_range(1, 8);
          v_cols    = $urandom_range(1, 8);
        end
        1: begin
          v_press   = 16'hFFFF;
          v_release = 16'hFFFF;
          v_poll    = 16'hFFFF;
          v_rows    = $urandom_range(8, 15);
          v_cols    = $urandom_range(8, 15);
        end
        2: begin
          v_press   = $urandom_range(0, 6);
          v_release = 16'hFFFF;
          v_poll    = $urandom_range(0, 1);
          v_rows    = 4'd8;
          v_cols    = 4'd8;
        end
        3: begin
          v_press   = 16'd0;
          v_release = 16'd0;
          v_poll    = $urandom_range(0, 65535);
          v_rows    = (ph < 5) ? 4'd1 : 4'($urandom_range(0, 15));
          v_cols    = (ph < 5) ? 4'd1 : 4'($urandom_range(0, 15));
        end
        default: begin
          v_press   = $urandom_range(20, 60);
          v_release = $urandom_range(20, 60);
          v_poll    = $urandom_range(4, 8);
          v_rows    = $urandom_range(0, 15);
          v_cols    = $urandom_range(0, 15);
        end
      endcase
      wait_drained();
      apb_write(reg_addr(REG_PRESS_MS), ($urandom() & 32'hFFFF_0000) | v_press);
      apb_write(reg_addr(REG_RELEASE_MS), ($urandom() & 32'hFFFF_0000) | v_release);
      apb_write(reg_addr(REG_POLL_MS), ($urandom() & 32'hFFFF_0000) | v_poll);
      apb_write(reg_addr(REG_ROWS), ($urandom() & 32'hFFFF_FFF0) | v_rows);
      apb_write(reg_addr(REG_PHYS_COLS), ($urandom() & 32'hFFFF_FFF0) | v_cols);
      if (ph % 3 == 0) apb_write(ADDR_UNMAPPED + 5'($urandom_range(0, 2) * 4), $urandom());
      check_regs();

      nrows   = (cfg_rows > NUM_ROWS) ? NUM_ROWS : cfg_rows;
      ncols   = (cfg_cols > NUM_PCOLS) ? NUM_PCOLS : cfg_cols;
      counted = 0;
      tries   = 0;
      while (counted < PHASE_WORDS && tries < 4 * PHASE_WORDS) begin
        mode = $urandom_range(0, 1);
        if (nrows > 0 && ncols > 0 && $urandom_range(0, 6) != 0) begin
          row = $urandom_range(0, nrows - 1);
          col = $urandom_range(0, ncols - 1);
        end else begin
          row = $urandom_range(0, 7);
          col = $urandom_range(0, 7);
        end
        repeat ($urandom_range(0, 2)) begin
          send_reading(mode, row, col, $urandom_range(0, 1), 1'b0, '0, taken);
          counted += taken;
          tries++;
        end
        target = $urandom_range(0, 1);
        lim    = debounce_limit(target);
        reps   = (lim < 12) ? lim + 1 + $urandom_range(0, 1) : $urandom_range(1, 4);
        repeat (reps) begin
          send_reading(mode, row, col, target, 1'b0, '0, taken);
          counted += taken;
          tries++;
        end
      end
    end
    wait_drained();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
